// File: sv/edsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event preamble deframer package
// Shared types, codes and constants for the preamble hunt and frame pass.
// ----------------------------------------------------------------------------
package edsd_pkg;

   // Hunt progress through the preamble words
   typedef enum logic [2:0] {
      HS_BYTE0     = 3'd0,
      HS_BYTE1     = 3'd1,
      HS_WORD_TEST = 3'd2,
      HS_W7FFF     = 3'd3,
      HS_W8000     = 3'd4,
      HS_WAAAA     = 3'd5
   } hunt_state_type;

   // Where the block stands within a frame
   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_PAYLOAD = 2'd2
   } frame_phase_type;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 1'b1;

   localparam logic [15:0] HEADER_SIZE_RESET = 16'd18;
   localparam logic [23:0] MAX_PAYLOAD_RESET = 24'd65536;

   // Preamble words and byte-hunt markers
   localparam logic [15:0] WORD_7FFF = 16'h7FFF;
   localparam logic [15:0] WORD_8000 = 16'h8000;
   localparam logic [15:0] WORD_AAAA = 16'hAAAA;
   localparam logic [7:0]  BYTE_SYNC0 = 8'h00;
   localparam logic [7:0]  BYTE_SYNC1 = 8'h80;

   // Fixed head: 14 preamble bytes plus 4 length bytes
   localparam logic [31:0] FIXED_HEAD = 32'd18;
   localparam int PREAMBLE_LEN = 14;
   localparam int PRE_IDX_W = $clog2(PREAMBLE_LEN);

   typedef struct packed {
      logic [15:0] header_size;
      logic [23:0] max_payload;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        frame_first;
      logic        frame_last;
      logic        length_error;
      logic [31:0] lost_bytes;
   } rsp_item_type;

   // Core status toward the output side
   typedef struct packed {
      logic         item_valid;
      logic         start_preamble;
      rsp_item_type item;
      logic [31:0]  lost_total;
   } core_out_type;

   // Canonical preamble FF 7F 00 80 (three times) then AA AA
   function automatic logic [7:0] preamble_byte(input logic [PRE_IDX_W-1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      if (idx >= PRE_IDX_W'(12)) begin
         b = 8'hAA;
      end else begin
         unique case (idx[1:0])
            2'd0: b = 8'hFF;
            2'd1: b = 8'h7F;
            2'd2: b = 8'h00;
            2'd3: b = 8'h80;
            default: b = 8'h00;
         endcase
      end
      return b;
   endfunction

   // Saturating 32-bit add
   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// File: sv/event_preamble_sync_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event preamble synchronising deframer
// Hunts the event preamble in a raw byte stream, then passes the canonical
// preamble, the packet length and the payload, with length checks.
// ----------------------------------------------------------------------------
// Items pass through the input register, then the result register.
// Throughput: one item per cycle while the result side takes results; the
// byte that completes a preamble yields 14 result items, and the next input
// item waits until they have all been loaded.
// Reset: synchronous, active high; clears the hunt, the lost-byte total and
// both channels, and loads header size 18 and maximum payload 65536.
module event_preamble_sync_deframer (
   input  logic                            clock,
   input  logic                            reset,
   // input items
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] rx_byte
   // result items
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [39:0]                     rsp_tdata,   // [7:0] out_byte, [39:8] lost_bytes
   output logic [1:0]                      rsp_tuser,   // [0] frame_first, [1] length_error
   output logic                            rsp_tlast,   // frame_last
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [edsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [edsd_pkg::CSR_DATA_W-1:0] csr_data
);
   import edsd_pkg::*;

   cfg_type      cfg;
   core_out_type status;

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;
   logic                 burst_ff, burst_in;
   logic [PRE_IDX_W-1:0] burst_idx_ff, burst_idx_in;

   logic out_free;
   logic in_advance;
   logic out_load;
   logic req_fire;

   assign csr_ready = 1'b1;

   edsd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   edsd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (in_advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .status  (status)
   );

   // Handshake and pipeline control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_advance = in_valid_ff && out_free && !burst_ff;
   assign req_tready = !in_valid_ff || in_advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      burst_in     = burst_ff;
      burst_idx_in = burst_idx_ff;
      out_load     = 1'b0;
      rsp_item_in  = rsp_item_ff;

      // Move the input register on
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (in_advance) begin
         in_valid_in = 1'b0;
      end

      // Load the result register: a processed item or the next preamble byte
      if (burst_ff && out_free) begin
         out_load                 = 1'b1;
         rsp_item_in.out_byte     = preamble_byte(burst_idx_ff);
         rsp_item_in.frame_first  = 1'b0;
         rsp_item_in.frame_last   = 1'b0;
         rsp_item_in.length_error = 1'b0;
         rsp_item_in.lost_bytes   = status.lost_total;
         if (burst_idx_ff == PRE_IDX_W'(PREAMBLE_LEN - 1)) begin
            burst_in = 1'b0;
         end else begin
            burst_idx_in = burst_idx_ff + PRE_IDX_W'(1);
         end
      end else if (in_advance && status.item_valid) begin
         out_load    = 1'b1;
         rsp_item_in = status.item;
         if (status.start_preamble) begin
            burst_in     = 1'b1;
            burst_idx_in = PRE_IDX_W'(1);
         end
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         burst_ff     <= 1'b0;
         burst_idx_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         burst_ff     <= burst_in;
         burst_idx_ff <= burst_idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_item_ff.lost_bytes, rsp_item_ff.out_byte};
   assign rsp_tuser  = {rsp_item_ff.length_error, rsp_item_ff.frame_first};
   assign rsp_tlast  = rsp_item_ff.frame_last;

endmodule

// File: sv/edsd_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Holds header size and maximum payload, written through the csr channel.
// ----------------------------------------------------------------------------
module edsd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [edsd_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [edsd_pkg::CSR_DATA_W-1:0] wr_data,
   output edsd_pkg::cfg_type               cfg
);
   import edsd_pkg::*;

   logic [15:0] header_size_ff;
   logic [23:0] max_payload_ff;

   // Take a write into the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         header_size_ff <= HEADER_SIZE_RESET;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (wr_en) begin
         unique case (wr_index)
            CSR_HEADER_SIZE: header_size_ff <= wr_data[15:0];
            CSR_MAX_PAYLOAD: max_payload_ff <= wr_data[23:0];
            default: ;
         endcase
      end
   end

   assign cfg.header_size = header_size_ff;
   assign cfg.max_payload = max_payload_ff;

endmodule

// File: sv/edsd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer hunt and frame engine
// Per-byte preamble hunt, length capture and check, payload count.
// ----------------------------------------------------------------------------
module edsd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [7:0]             rx_byte,
   input  edsd_pkg::cfg_type      cfg,
   output edsd_pkg::core_out_type status
);
   import edsd_pkg::*;

   hunt_state_type  hunt_state_ff, hunt_state_in;
   frame_phase_type phase_ff, phase_in;
   logic [7:0]  low_hold_ff, low_hold_in;
   logic        half_ff, half_in;
   logic [31:0] since_sync_ff, since_sync_in;
   logic [31:0] lost_ff, lost_in;
   logic [31:0] accum_ff, accum_in;
   logic [1:0]  len_idx_ff, len_idx_in;
   logic [31:0] remain_ff, remain_in;

   logic [31:0] since_inc;
   logic [15:0] word;
   logic [31:0] payload_len;
   logic        len_bad;
   logic        goto_discard;
   logic        goto_restart;

   // Next state and result for one byte
   always_comb begin
      hunt_state_in = hunt_state_ff;
      phase_in      = phase_ff;
      low_hold_in   = low_hold_ff;
      half_in       = half_ff;
      since_sync_in = since_sync_ff;
      lost_in       = lost_ff;
      accum_in      = accum_ff;
      len_idx_in    = len_idx_ff;
      remain_in     = remain_ff;
      goto_discard  = 1'b0;
      goto_restart  = 1'b0;

      status.item_valid        = 1'b0;
      status.start_preamble    = 1'b0;
      status.item.out_byte     = rx_byte;
      status.item.frame_first  = 1'b0;
      status.item.frame_last   = 1'b0;
      status.item.length_error = 1'b0;

      since_inc   = (since_sync_ff == 32'hFFFF_FFFF) ? since_sync_ff : since_sync_ff + 32'd1;
      word        = {rx_byte, low_hold_ff};
      payload_len = 32'd0;
      len_bad     = 1'b0;

      unique case (phase_ff)
         PH_LENGTH: begin
            status.item_valid = 1'b1;
            unique case (len_idx_ff)
               2'd0: accum_in[7:0]   = rx_byte;
               2'd1: accum_in[15:8]  = rx_byte;
               2'd2: accum_in[23:16] = rx_byte;
               2'd3: accum_in[31:24] = rx_byte;
               default: ;
            endcase
            if (len_idx_ff != 2'd3) begin
               len_idx_in = len_idx_ff + 2'd1;
            end else begin
               // Check the complete length
               payload_len = accum_in - {16'd0, cfg.header_size};
               len_bad = (accum_in < {16'd0, cfg.header_size}) ||
                         (accum_in < FIXED_HEAD) ||
                         (payload_len > {8'd0, cfg.max_payload});
               if (len_bad) begin
                  status.item.out_byte     = 8'h00;
                  status.item.length_error = 1'b1;
                  remain_in    = 32'd0;
                  goto_restart = 1'b1;
               end else begin
                  remain_in = accum_in - FIXED_HEAD;
                  if (remain_in == 32'd0) begin
                     status.item.frame_last = 1'b1;
                     goto_restart = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            status.item_valid = 1'b1;
            if (remain_ff != 32'd0) begin
               remain_in = remain_ff - 32'd1;
            end
            if (remain_in == 32'd0) begin
               status.item.frame_last = 1'b1;
               goto_restart = 1'b1;
            end
         end
         default: begin
            since_sync_in = since_inc;
            unique case (hunt_state_ff)
               HS_BYTE0: begin
                  if (rx_byte == BYTE_SYNC0) begin
                     hunt_state_in = HS_BYTE1;
                  end else begin
                     goto_discard = 1'b1;
                  end
               end
               HS_BYTE1: begin
                  if (rx_byte == BYTE_SYNC1) begin
                     hunt_state_in = HS_W7FFF;
                     half_in       = 1'b0;
                  end else begin
                     goto_discard = 1'b1;
                  end
               end
               default: begin
                  if (!half_ff) begin
                     // Hold the low half of the word
                     low_hold_in = rx_byte;
                     half_in     = 1'b1;
                  end else begin
                     half_in = 1'b0;
                     priority if (hunt_state_ff == HS_WORD_TEST && word == WORD_8000) begin
                        hunt_state_in = HS_W7FFF;
                     end else if (hunt_state_ff != HS_W8000 && word == WORD_7FFF) begin
                        hunt_state_in = HS_W8000;
                     end else if (hunt_state_ff == HS_W8000 && word == WORD_8000) begin
                        hunt_state_in = HS_WAAAA;
                     end else if (hunt_state_ff == HS_WAAAA && word == WORD_AAAA) begin
                        // Preamble complete: start the burst and the length
                        status.item_valid       = 1'b1;
                        status.start_preamble   = 1'b1;
                        status.item.out_byte    = preamble_byte(PRE_IDX_W'(0));
                        status.item.frame_first = 1'b1;
                        phase_in      = PH_LENGTH;
                        len_idx_in    = 2'd0;
                        accum_in      = 32'd0;
                        since_sync_in = 32'd0;
                     end else begin
                        goto_discard = 1'b1;
                     end
                  end
               end
            endcase
         end
      endcase

      // Drop the bytes since the last sync point
      if (goto_discard) begin
         lost_in       = sat_add(lost_ff, since_inc);
         since_sync_in = 32'd0;
         hunt_state_in = HS_BYTE0;
      end

      // Resume the hunt in word mode
      if (goto_restart) begin
         phase_in      = PH_HUNT;
         hunt_state_in = HS_WORD_TEST;
         half_in       = 1'b0;
         low_hold_in   = 8'h00;
         since_sync_in = 32'd0;
      end

      status.item.lost_bytes = lost_in;
      status.lost_total      = lost_ff;
   end

   // Advance the state on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_state_ff <= HS_WORD_TEST;
         phase_ff      <= PH_HUNT;
         low_hold_ff   <= 8'h00;
         half_ff       <= 1'b0;
         since_sync_ff <= 32'd0;
         lost_ff       <= 32'd0;
         accum_ff      <= 32'd0;
         len_idx_ff    <= 2'd0;
         remain_ff     <= 32'd0;
      end else if (advance) begin
         hunt_state_ff <= hunt_state_in;
         phase_ff      <= phase_in;
         low_hold_ff   <= low_hold_in;
         half_ff       <= half_in;
         since_sync_ff <= since_sync_in;
         lost_ff       <= lost_in;
         accum_ff      <= accum_in;
         len_idx_ff    <= len_idx_in;
         remain_ff     <= remain_in;
      end
   end

endmodule
